FILE: design/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// Shared types, constants and byte-level functions of the AES engine.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int BLOCK_BITS = 128;
    localparam int PART_BITS  = 64;
    localparam int WORD_BITS  = 32;

    typedef enum logic [2:0] {
        REG_KEY_SIZE   = 3'd0,
        REG_KEY_PART_0 = 3'd1,
        REG_KEY_PART_1 = 3'd2,
        REG_KEY_PART_2 = 3'd3,
        REG_KEY_PART_3 = 3'd4
    } t_reg_index;

    typedef enum logic [1:0] {
        KEY_SIZE_128 = 2'd0,
        KEY_SIZE_192 = 2'd1,
        KEY_SIZE_256 = 2'd2
    } t_key_size;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND,
        ST_DONE
    } t_state;

    // Control handed from the sequencer to the column cells in each cycle.
    typedef struct packed {
        logic load;     // capture the input block
        logic step;     // apply one transformation step
        logic decrypt;  // inverse cipher
        logic first;    // initial key addition only
        logic last;     // final round: no column mixing
    } t_cell_ctrl;

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [3:0] y);
        logic [7:0] acc;
        logic [7:0] p;
        acc = 8'h00;
        p   = x;
        for (int i = 0; i < 4; i++) begin
            if (y[i]) acc = acc ^ p;
            p = xtime(p);
        end
        return acc;
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
            8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
            8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
            8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
            8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
            8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
            8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
            8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
            8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
            8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
            8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
            8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
            8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
            8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
            8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
            8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
            8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
        };
        return t[x];
    endfunction

    function automatic logic [WORD_BITS-1:0] sub_word(input logic [WORD_BITS-1:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

FILE: design/aes_ram.sv
// ----------------------------------------------------------------------------
// AES generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 60
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/aes_column_cell.sv
// ----------------------------------------------------------------------------
// AES column cell
// Holds one state column; per step it takes row-shifted bytes from its
// neighbors, substitutes, mixes (not in the last round) and adds the key
// word, adding it before mixing in decryption; the first step only adds it.
// ----------------------------------------------------------------------------
module aes_column_cell (
    input  logic                       i_clk,
    input  aes_pkg::t_cell_ctrl        i_ctrl,
    input  logic [31:0]                i_load_col,
    input  logic [31:0]                i_key_word,
    input  logic [7:0]                 i_row1,
    input  logic [7:0]                 i_row2,
    input  logic [7:0]                 i_row3,
    output logic [31:0]                o_col
);
    import aes_pkg::*;

    logic [31:0] r_col;
    logic [31:0] n_col;
    logic [7:0]  b [4];
    logic [7:0]  m [4];
    logic [7:0]  k [4];
    logic [3:0]  coef [4];

    always_comb begin
        b[0] = r_col[31:24];
        b[1] = i_row1;
        b[2] = i_row2;
        b[3] = i_row3;
        k[0] = i_key_word[31:24];
        k[1] = i_key_word[23:16];
        k[2] = i_key_word[15:8];
        k[3] = i_key_word[7:0];
        if (i_ctrl.decrypt) begin
            coef = '{4'd14, 4'd11, 4'd13, 4'd9};
        end else begin
            coef = '{4'd2, 4'd3, 4'd1, 4'd1};
        end
        for (int j = 0; j < 4; j++) begin
            if (i_ctrl.first) begin
                m[j] = r_col[31-8*j -: 8];
            end else if (i_ctrl.decrypt) begin
                m[j] = inv_sbox(b[j]) ^ k[j];
            end else begin
                m[j] = sbox(b[j]);
            end
        end
        n_col = r_col;
        for (int j = 0; j < 4; j++) begin
            if (i_ctrl.first) begin
                n_col[31-8*j -: 8] = m[j] ^ k[j];
            end else if (i_ctrl.last) begin
                n_col[31-8*j -: 8] = i_ctrl.decrypt ? m[j] : (m[j] ^ k[j]);
            end else begin
                n_col[31-8*j -: 8] = gf_mul(m[0], coef[(0-j)&3]) ^ gf_mul(m[1], coef[(1-j)&3])
                                   ^ gf_mul(m[2], coef[(2-j)&3]) ^ gf_mul(m[3], coef[(3-j)&3])
                                   ^ (i_ctrl.decrypt ? 8'h00 : k[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_col <= i_load_col;
        end else if (i_ctrl.step) begin
            r_col <= n_col;
        end
    end

    assign o_col = r_col;
endmodule

FILE: design/aes_block_cipher_engine.sv
// ----------------------------------------------------------------------------
// AES block cipher engine
// A taken request loads the cells, runs the initial key addition and the
// Nr rounds (Nr = 10, 12 or 14) and registers the result; a new request is
// taken only back in idle. The first request after a key or size write
// first expands the key (Nk = 4, 6 or 8). The row of four column cells
// applies one round per cycle, fed by one round-key store read per cycle.
// Reset (synchronous, active low) clears control and key registers; the
// result strobe lasts one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module aes_block_cipher_engine #(
    parameter int ROUND_KEY_WORDS = 60
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_command,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    output logic        o_result_valid,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low
);
    import aes_pkg::*;

    localparam int AW = $clog2(ROUND_KEY_WORDS);

    // Configuration registers.
    logic [1:0]  r_key_size;
    logic [63:0] r_key_part [4];
    logic        r_sched_ready;

    // The effective key length, falling back when the store is too small.
    logic [3:0] nk;
    logic [3:0] nr;
    always_comb begin
        priority if (r_key_size != KEY_SIZE_128 && r_key_size != KEY_SIZE_192
                     && 4*15 <= ROUND_KEY_WORDS) begin
            nk = 4'd8;
        end else if (r_key_size != KEY_SIZE_128 && 4*13 <= ROUND_KEY_WORDS) begin
            nk = 4'd6;
        end else begin
            nk = 4'd4;
        end
        nr = nk + 4'd6;
    end

    t_state r_state, n_state;
    logic [AW:0] r_widx;         // next schedule word to produce
    logic [AW:0] r_total;
    logic [3:0]  r_kmod;         // widx mod nk
    logic [7:0]  r_rc;
    logic [31:0] r_win [8];      // last nk schedule words, newest in entry 0
    logic        r_dec;
    logic [3:0]  r_round;
    logic [3:0]  r_cnt;
    logic [127:0] r_result;
    logic        r_valid;

    // Schedule word generation from the sliding window.
    logic [31:0] tmp_word, new_word;
    always_comb begin
        tmp_word = r_win[0];
        if (r_kmod == 4'd0) begin
            tmp_word = sub_word({r_win[0][23:0], r_win[0][31:24]}) ^ {r_rc, 24'h0};
        end else if (nk == 4'd8 && r_kmod == 4'd4) begin
            tmp_word = sub_word(r_win[0]);
        end
        new_word = r_win[3'(nk - 4'd1)] ^ tmp_word;
    end

    // Round-key store: four column RAMs so one round key is read per cycle.
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          ram_we;
    logic [31:0]   key_col [4];
    logic [3:0]    rd_round;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_widx[AW-1:0];
        ram_wdata = new_word;
        if (r_state == ST_EXPAND && r_widx < r_total) begin
            ram_we = 1'b1;
            if (r_widx < {1'b0, AW'(nk)}) begin
                ram_wdata = r_widx[0] ? r_key_part[r_widx[2:1]][31:0]
                                      : r_key_part[r_widx[2:1]][63:32];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_store
            aes_ram #(.WIDTH(32), .DEPTH((ROUND_KEY_WORDS + 3) / 4)) u_ram (
                .i_clk  (i_clk),
                .i_we   (ram_we && ram_waddr[1:0] == 2'(g)),
                .i_waddr(($clog2((ROUND_KEY_WORDS + 3) / 4))'(ram_waddr >> 2)),
                .i_wdata(ram_wdata),
                .i_raddr(($clog2((ROUND_KEY_WORDS + 3) / 4))'(rd_round)),
                .o_rdata(key_col[g])
            );
        end
    endgenerate

    // Read address runs one round ahead of the cells, as the store registers
    // its read data. Outside the rounds it points at the first round key, so
    // that key is on hand when the cells start.
    always_comb begin
        if (r_state == ST_ROUND) begin
            rd_round = r_dec ? (r_round - 4'd1) : (r_round + 4'd1);
        end else begin
            rd_round = r_round;
        end
    end

    // Cell row.
    t_cell_ctrl ctrl;
    logic [31:0] col [4];
    logic [31:0] load_col [4];
    always_comb begin
        load_col[0] = r_result[127:96];
        load_col[1] = r_result[95:64];
        load_col[2] = r_result[63:32];
        load_col[3] = r_result[31:0];
    end

    generate
        for (g = 0; g < 4; g++) begin : g_cell
            // Encryption row r takes from column g+r, decryption from g-r.
            aes_column_cell u_cell (
                .i_clk     (i_clk),
                .i_ctrl    (ctrl),
                .i_load_col(load_col[g]),
                .i_key_word(key_col[g]),
                .i_row1    (r_dec ? col[(g+3)%4][23:16] : col[(g+1)%4][23:16]),
                .i_row2    (col[(g+2)%4][15:8]),
                .i_row3    (r_dec ? col[(g+1)%4][7:0] : col[(g+3)%4][7:0]),
                .o_col     (col[g])
            );
        end
    endgenerate

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = r_sched_ready ? ST_LOAD : ST_EXPAND;
                end
            end
            ST_EXPAND: begin
                if (r_widx >= r_total) n_state = ST_LOAD;
            end
            ST_LOAD: n_state = ST_ROUND;
            ST_ROUND: begin
                if (r_cnt == nr) n_state = ST_DONE;
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Output and control logic.
    always_comb begin
        ctrl         = '0;
        ctrl.decrypt = r_dec;
        ctrl.load    = (r_state == ST_LOAD);
        ctrl.step    = (r_state == ST_ROUND);
        ctrl.first   = (r_state == ST_ROUND) && (r_cnt == 4'd0);
        ctrl.last    = (r_state == ST_ROUND) && (r_cnt == nr);
        busy         = (r_state != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_key_size    <= 2'd0;
            r_key_part    <= '{default: '0};
            r_sched_ready <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_DONE);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_KEY_SIZE:   r_key_size    <= i_cfg_data[1:0];
                    REG_KEY_PART_0: r_key_part[0] <= i_cfg_data;
                    REG_KEY_PART_1: r_key_part[1] <= i_cfg_data;
                    REG_KEY_PART_2: r_key_part[2] <= i_cfg_data;
                    REG_KEY_PART_3: r_key_part[3] <= i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_index <= REG_KEY_PART_3) r_sched_ready <= 1'b0;
            end else if (r_state == ST_EXPAND && r_widx >= r_total) begin
                r_sched_ready <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_widx   <= '0;
                r_kmod   <= '0;
                r_rc     <= 8'h01;
                r_total  <= (AW+1)'(4 * (nk + 4'd7));
                r_cnt    <= '0;
                if (start) begin
                    r_dec    <= i_command;
                    r_round  <= i_command ? nr : 4'd0;
                    r_result <= {i_block_high, i_block_low};
                end
            end
            ST_EXPAND: begin
                if (r_widx < r_total) begin
                    r_widx <= r_widx + 1'b1;
                    for (int i = 7; i > 0; i--) r_win[i] <= r_win[i-1];
                    r_win[0] <= ram_wdata;
                    if (r_widx >= {1'b0, AW'(nk)}) begin
                        r_kmod <= (r_kmod == nk - 4'd1) ? 4'd0 : r_kmod + 4'd1;
                        if (r_kmod == 4'd0) r_rc <= xtime(r_rc);
                    end
                end
            end
            ST_LOAD: ;
            ST_ROUND: begin
                r_cnt   <= r_cnt + 4'd1;
                r_round <= r_dec ? r_round - 4'd1 : r_round + 4'd1;
            end
            ST_DONE: begin
                r_result <= {col[0], col[1], col[2], col[3]};
            end
            default: ;
        endcase
    end

    assign o_result_valid = r_valid;
    assign o_result_high  = r_result[127:64];
    assign o_result_low   = r_result[63:0];
endmodule
